FILE: rtl/bmpd_pkg.sv
// package for the bmp24 stream decoder: transaction types and header constants
// no dependencies
`timescale 1ns / 1ps

package bmpd_pkg;

  // input transaction: one raw file byte with its start-of-image flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_item_t;

  // output transaction: one decoded pixel with its screen coordinate
  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } out_item_t;

  // configuration register indexes
  localparam logic [0:0] CFG_ORIGIN_X = 1'b0;
  localparam logic [0:0] CFG_ORIGIN_Y = 1'b1;

  // signature bytes
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  // file positions of the last byte of each header field
  localparam logic [31:0] POS_SIG0       = 32'd0;
  localparam logic [31:0] POS_SIG1       = 32'd1;
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_WIDTH_END  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END = 32'd25;
  localparam logic [31:0] POS_BPP_END    = 32'd29;
  localparam logic [31:0] POS_COMP_END   = 32'd33;
  localparam logic [31:0] HEADER_LEN     = 32'd34;

  localparam logic [15:0] BPP_24 = 16'd24;

  // byte phase within a B,G,R triple
  localparam logic [1:0] PHASE_BLUE  = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;

endpackage

FILE: rtl/bmp24_stream_decoder.sv
// a byte accepted into the input register is parsed once the output buffer has
// room; a completed pixel is registered into the output buffer by that parse step
// throughput: one byte per cycle while the output buffer has room, set by the single parse step on the input register
// reset (rst_ni low, asynchronous): buffers empty, origins zero, parser rejecting
// every byte until one arrives flagged as start of image
`timescale 1ns / 1ps

// top level of the bmp24 stream decoder: input register, parser, output buffer
// depends on bmpd_pkg, bmpd_parser and bmpd_out_buf
module bmp24_stream_decoder #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte stream in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bmpd_pkg::in_item_t  in_item_i,
  // pixel stream out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bmpd_pkg::out_item_t out_item_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i
);

  // input register holding one byte transaction
  logic               stage_valid_q, stage_valid_d;
  bmpd_pkg::in_item_t stage_item_q;

  // origin registers
  logic [15:0] origin_x_q, origin_x_d;
  logic [15:0] origin_y_q, origin_y_d;

  logic                buf_room;
  logic                advance;
  logic                in_accept;
  logic                res_valid;
  bmpd_pkg::out_item_t res_item;

  // the staged byte is parsed whenever the buffer can take a possible pixel
  assign advance    = stage_valid_q && buf_room;
  // a byte may enter while an earlier one is parsed in the same cycle
  assign in_ready_o = !stage_valid_q || buf_room;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_accept) begin
      stage_valid_d = 1'b1;
    end else if (advance) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  // payload register, loaded only on an accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_item_q <= in_item_i;
    end
  end

  // configuration decode; writes must arrive only while the block is idle, which the block itself does not enforce
  always_comb begin
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bmpd_pkg::CFG_ORIGIN_X: origin_x_d = cfg_wdata_i;
        bmpd_pkg::CFG_ORIGIN_Y: origin_y_d = cfg_wdata_i;
        default: begin
          origin_x_d = origin_x_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else begin
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
    end
  end

  // header parse, row/column tracking and pixel assembly
  bmpd_parser #(
    .MAX_SIDE (MAX_SIDE)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (stage_item_q),
    .origin_x_i  (origin_x_q),
    .origin_y_i  (origin_y_q),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  // result register with skid entry so parsing continues while output stalls, until the skid entry fills
  bmpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_item_i (res_item),
    .room_o      (buf_room),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_ready_i (out_ready_i)
  );

endmodule

FILE: rtl/bmpd_parser.sv
// header parser and pixel assembler of the bmp24 stream decoder
// depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_parser #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bmpd_pkg::in_item_t  item_i,
  input  logic [15:0]         origin_x_i,
  input  logic [15:0]         origin_y_i,
  output logic                res_valid_o,
  output bmpd_pkg::out_item_t res_item_o
);

  localparam logic [31:0] MaxSide = 32'(MAX_SIDE);

  logic [31:0] pos_q, pos_d, pos_b;
  logic [31:0] offset_q, offset_d, offset_b;
  logic [12:0] width_q, width_d, width_b;
  logic [12:0] height_q, height_d, height_b;
  logic        rows_down_q, rows_down_d, rows_down_b;
  logic [31:0] hword_q, hword_d, hword_b;
  logic        rejected_q, rejected_d, rejected_b;
  logic [12:0] row_q, row_d, row_b;
  logic [12:0] col_q, col_d, col_b;
  logic [1:0]  phase_q, phase_d, phase_b;
  logic [1:0]  pad_q, pad_d, pad_b;
  logic [7:0]  blue_q, blue_d, blue_b;
  logic [7:0]  green_q, green_d, green_b;

  logic [31:0] hw_next;
  logic [31:0] height_mag;
  logic [12:0] row_inc;
  logic [12:0] col_inc;
  logic [12:0] screen_row;
  logic        sof;

  assign sof = item_i.start_of_image;

  // a start flag restarts from the all-zero state
  assign pos_b       = sof ? '0 : pos_q;
  assign offset_b    = sof ? '0 : offset_q;
  assign width_b     = sof ? '0 : width_q;
  assign height_b    = sof ? '0 : height_q;
  assign rows_down_b = sof ? 1'b0 : rows_down_q;
  assign hword_b     = sof ? '0 : hword_q;
  assign rejected_b  = sof ? 1'b0 : rejected_q;
  assign row_b       = sof ? '0 : row_q;
  assign col_b       = sof ? '0 : col_q;
  assign phase_b     = sof ? '0 : phase_q;
  assign pad_b       = sof ? '0 : pad_q;
  assign blue_b      = sof ? '0 : blue_q;
  assign green_b     = sof ? '0 : green_q;

  assign hw_next    = {item_i.data_byte, hword_b[31:8]};
  assign height_mag = hw_next[31] ? (32'd0 - hw_next) : hw_next;
  assign row_inc    = row_b + 13'd1;
  assign col_inc    = col_b + 13'd1;
  assign screen_row = rows_down_b ? row_b : (height_b - 13'd1 - row_b);

  always_comb begin
    pos_d       = pos_q;
    offset_d    = offset_q;
    width_d     = width_q;
    height_d    = height_q;
    rows_down_d = rows_down_q;
    hword_d     = hword_q;
    rejected_d  = rejected_q;
    row_d       = row_q;
    col_d       = col_q;
    phase_d     = phase_q;
    pad_d       = pad_q;
    blue_d      = blue_q;
    green_d     = green_q;
    res_valid_o = 1'b0;
    res_item_o.pixel_x = origin_x_i + {3'b000, col_b};
    res_item_o.pixel_y = origin_y_i + {3'b000, screen_row};
    res_item_o.red     = item_i.data_byte;
    res_item_o.green   = green_b;
    res_item_o.blue    = blue_b;

    if (step_i) begin
      pos_d       = pos_b;
      offset_d    = offset_b;
      width_d     = width_b;
      height_d    = height_b;
      rows_down_d = rows_down_b;
      hword_d     = hword_b;
      rejected_d  = rejected_b;
      row_d       = row_b;
      col_d       = col_b;
      phase_d     = phase_b;
      pad_d       = pad_b;
      blue_d      = blue_b;
      green_d     = green_b;

      if (!rejected_b) begin
        // saturating file position
        if (pos_b != '1) begin
          pos_d = pos_b + 32'd1;
        end

        if (pos_b < bmpd_pkg::HEADER_LEN) begin
          hword_d = hw_next;
          if (pos_b == bmpd_pkg::POS_SIG0) begin
            if (item_i.data_byte != bmpd_pkg::SIG_B) begin
              rejected_d = 1'b1;
            end
          end else if (pos_b == bmpd_pkg::POS_SIG1) begin
            if (item_i.data_byte != bmpd_pkg::SIG_M) begin
              rejected_d = 1'b1;
            end
          end else if (pos_b == bmpd_pkg::POS_OFFSET_END) begin
            offset_d = hw_next;
          end else if (pos_b == bmpd_pkg::POS_WIDTH_END) begin
            // negative width leaves zero, caught at the end of the header
            if (hw_next[31]) begin
              width_d = '0;
            end else if (hw_next > MaxSide) begin
              rejected_d = 1'b1;
            end else begin
              width_d = hw_next[12:0];
            end
          end else if (pos_b == bmpd_pkg::POS_HEIGHT_END) begin
            rows_down_d = hw_next[31];
            if (height_mag > MaxSide) begin
              rejected_d = 1'b1;
            end else begin
              height_d = height_mag[12:0];
            end
          end else if (pos_b == bmpd_pkg::POS_BPP_END) begin
            if (hw_next[31:16] != bmpd_pkg::BPP_24) begin
              rejected_d = 1'b1;
            end
          end else if (pos_b == bmpd_pkg::POS_COMP_END) begin
            if (hw_next != '0 || offset_b < bmpd_pkg::HEADER_LEN) begin
              rejected_d = 1'b1;
            end else if (width_b == '0 || height_b == '0) begin
              rejected_d = 1'b1;
            end
          end
        end else if (pos_b < offset_b) begin
          // gap before the pixel data
        end else if (pad_b != '0) begin
          pad_d = pad_b - 2'd1;
          if (pad_b == 2'd1) begin
            col_d = '0;
            row_d = row_inc;
            if (row_inc >= height_b) begin
              rejected_d = 1'b1;
            end
          end
        end else begin
          case (phase_b)
            bmpd_pkg::PHASE_BLUE: begin
              blue_d  = item_i.data_byte;
              phase_d = bmpd_pkg::PHASE_GREEN;
            end
            bmpd_pkg::PHASE_GREEN: begin
              green_d = item_i.data_byte;
              phase_d = phase_b + 2'd1;
            end
            default: begin
              // red byte completes the pixel
              phase_d     = bmpd_pkg::PHASE_BLUE;
              res_valid_o = 1'b1;
              col_d       = col_inc;
              if (col_inc >= width_b) begin
                pad_d = width_b[1:0];
                if (width_b[1:0] == 2'd0) begin
                  col_d = '0;
                  row_d = row_inc;
                  if (row_inc >= height_b) begin
                    rejected_d = 1'b1;
                  end
                end
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      offset_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      rows_down_q <= 1'b0;
      hword_q     <= '0;
      rejected_q  <= 1'b1;
      row_q       <= '0;
      col_q       <= '0;
      phase_q     <= '0;
      pad_q       <= '0;
      blue_q      <= '0;
      green_q     <= '0;
    end else begin
      pos_q       <= pos_d;
      offset_q    <= offset_d;
      width_q     <= width_d;
      height_q    <= height_d;
      rows_down_q <= rows_down_d;
      hword_q     <= hword_d;
      rejected_q  <= rejected_d;
      row_q       <= row_d;
      col_q       <= col_d;
      phase_q     <= phase_d;
      pad_q       <= pad_d;
      blue_q      <= blue_d;
      green_q     <= green_d;
    end
  end

endmodule

FILE: rtl/bmpd_out_buf.sv
// two-entry output buffer: result register plus skid register
// depends on bmpd_pkg
`timescale 1ns / 1ps

module bmpd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bmpd_pkg::out_item_t push_item_i,
  output logic                room_o,
  output logic                out_valid_o,
  output bmpd_pkg::out_item_t out_item_o,
  input  logic                out_ready_i
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  bmpd_pkg::out_item_t out_item_q, out_item_d;
  bmpd_pkg::out_item_t skid_item_q, skid_item_d;
  logic                pop;

  assign pop         = out_valid_q && out_ready_i;
  assign room_o      = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_item_d   = out_item_q;
    skid_item_d  = skid_item_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_item_d   = skid_item_q;
        skid_valid_d = push_i;
        skid_item_d  = push_item_i;
      end else begin
        out_valid_d = push_i;
        out_item_d  = push_item_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_item_d  = push_item_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_item_d  = push_item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    skid_item_q <= skid_item_d;
  end

endmodule

FILE: rtl/bmpd_checker.sv
// port-level checks for the bmp24 stream decoder, bound to the top level
// depends on bmpd_pkg and bmp24_stream_decoder
`timescale 1ns / 1ps

module bmpd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bmpd_pkg::out_item_t out_item_o
);

  // a stalled pixel transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled pixel transaction changed");

  // input back-pressure only when a pixel is waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // reset empties the output
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind bmp24_stream_decoder bmpd_checker u_bmpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

FILE: bench/tb_bmp24_stream_decoder.sv
// self-checking testbench for bmp24_stream_decoder: streams directed and random bmp files,
// predicts every decoded pixel and compares it field by field against the output stream
// depends on bmpd_pkg and the bmp24_stream_decoder rtl
`timescale 1ns / 1ps

module tb_bmp24_stream_decoder;
  import bmpd_pkg::*;

  localparam int unsigned MAX_SIDE      = 4096;
  localparam int unsigned CYCLE_LIMIT   = 600_000;
  localparam int unsigned DRAIN_LIMIT   = 5_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 19;
  localparam int unsigned RANDOM_BYTES  = 200;
  localparam int unsigned NO_LIMIT      = 32'hFFFF_FFFF;
  localparam logic [1:0]  PHASE_RED     = 2'd2;

  // pixel predictor and queue of pixels still owed by the block
  class pixel_scoreboard;
    logic [15:0] origin_x, origin_y;
    logic [31:0] file_pos, data_offset, hdr_word;
    logic [12:0] img_w, img_h, row_idx, col_idx;
    logic [1:0]  byte_phase, pad_left;
    logic [7:0]  blue_hold, green_hold;
    bit          rows_down, skipping;
    out_item_t   pixel_q[$];
    int unsigned pixels_checked, errors;

    function new();
      origin_x = '0;
      origin_y = '0;
      clear_parser();
      skipping = 1'b1;
    endfunction

    function void clear_parser();
      file_pos    = '0;
      data_offset = '0;
      hdr_word    = '0;
      img_w       = '0;
      img_h       = '0;
      row_idx     = '0;
      col_idx     = '0;
      byte_phase  = PHASE_BLUE;
      pad_left    = '0;
      blue_hold   = '0;
      green_hold  = '0;
      rows_down   = 1'b0;
      skipping    = 1'b0;
    endfunction

    function void set_origin(logic [0:0] idx, logic [15:0] val);
      if (idx == CFG_ORIGIN_X) begin
        origin_x = val;
      end else begin
        origin_y = val;
      end
    endfunction

    function int unsigned pending();
      return pixel_q.size();
    endfunction

    function void end_row();
      col_idx = '0;
      row_idx = row_idx + 13'd1;
      if (row_idx >= img_h) begin
        skipping = 1'b1;
      end
    endfunction

    function void parse_header(logic [31:0] pos, logic [7:0] b);
      logic [31:0] mag;
      hdr_word = {b, hdr_word[31:8]};
      if (pos == POS_SIG0 && b != SIG_B) begin
        skipping = 1'b1;
      end else if (pos == POS_SIG1 && b != SIG_M) begin
        skipping = 1'b1;
      end else if (pos == POS_OFFSET_END) begin
        data_offset = hdr_word;
      end else if (pos == POS_WIDTH_END) begin
        if (hdr_word[31]) begin
          img_w = '0;
        end else if (hdr_word > MAX_SIDE) begin
          skipping = 1'b1;
        end else begin
          img_w = hdr_word[12:0];
        end
      end else if (pos == POS_HEIGHT_END) begin
        rows_down = hdr_word[31];
        mag = rows_down ? 32'd0 - hdr_word : hdr_word;
        if (mag > MAX_SIDE) begin
          skipping = 1'b1;
        end else begin
          img_h = mag[12:0];
        end
      end else if (pos == POS_BPP_END) begin
        if (hdr_word[31:16] != BPP_24) begin
          skipping = 1'b1;
        end
      end else if (pos == POS_COMP_END) begin
        if (hdr_word != '0 || data_offset < HEADER_LEN) begin
          skipping = 1'b1;
        end else if (img_w == '0 || img_h == '0) begin
          skipping = 1'b1;
        end
      end
    endfunction

    function void note_byte(in_item_t item);
      logic [31:0] pos;
      logic [15:0] screen_row;
      out_item_t   px;
      if (item.start_of_image) begin
        clear_parser();
      end
      if (skipping) begin
        return;
      end
      pos = file_pos;
      if (file_pos != '1) begin
        file_pos = file_pos + 32'd1;
      end
      if (pos < HEADER_LEN) begin
        parse_header(pos, item.data_byte);
        return;
      end
      if (pos < data_offset) begin
        return;
      end
      if (pad_left != '0) begin
        pad_left = pad_left - 2'd1;
        if (pad_left == '0) begin
          end_row();
        end
        return;
      end
      if (byte_phase == PHASE_BLUE) begin
        blue_hold  = item.data_byte;
        byte_phase = PHASE_GREEN;
        return;
      end
      if (byte_phase == PHASE_GREEN) begin
        green_hold = item.data_byte;
        byte_phase = PHASE_RED;
        return;
      end
      byte_phase = PHASE_BLUE;
      screen_row = rows_down ? 16'(row_idx) : 16'(img_h) - 16'd1 - 16'(row_idx);
      px.pixel_x = origin_x + 16'(col_idx);
      px.pixel_y = origin_y + screen_row;
      px.red     = item.data_byte;
      px.green   = green_hold;
      px.blue    = blue_hold;
      pixel_q.push_back(px);
      col_idx = col_idx + 13'd1;
      if (col_idx >= img_w) begin
        pad_left = img_w[1:0];
        if (pad_left == '0) begin
          end_row();
        end
      end
    endfunction

    function void compare_field(string field_name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t ns: pixel with none expected, actual x=%0d y=%0d r=%0d g=%0d b=%0d",
                 $time, got.pixel_x, got.pixel_y, got.red, got.green, got.blue);
        return;
      end
      want = pixel_q.pop_front();
      pixels_checked++;
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
    endfunction

    function void flush_missing();
      $display("%0t ns: %0d expected pixels never arrived, expected next x=%0d y=%0d, actual none",
               $time, pixel_q.size(), pixel_q[0].pixel_x, pixel_q[0].pixel_y);
      errors += pixel_q.size();
      pixel_q.delete();
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_item_i   = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  bit              steady_flow     = 1'b0;
  int unsigned     cycle_count     = 0;
  int unsigned     file_bytes_sent = 0;
  int unsigned     files_sent      = 0;
  int unsigned     origin_settings = 0;
  logic [7:0]      file_bytes[$];
  pixel_scoreboard pixel_sb        = new();

  bmp24_stream_decoder #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // watchdog: a hung handshake or a lost pixel ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached with %0d pixels outstanding",
               $time, pixel_sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // pixel sink: random back-pressure, none while the steady stretch runs
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // output monitor: every accepted pixel transaction goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixel_sb.check_pixel(out_item_o);
    end
  end

  // byte source: optional idle gap, then hold valid until the transaction is taken
  task send_byte(logic [7:0] d, logic sof);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= in_item_t'({d, sof});
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixel_sb.note_byte(in_item_i);
  endtask

  // whole file, start flag on its first byte only
  task send_file();
    foreach (file_bytes[i]) begin
      send_byte(file_bytes[i], i == 0);
    end
    file_bytes_sent += file_bytes.size();
    files_sent++;
    file_bytes.delete();
  endtask

  // stop the source, let the owed pixels drain, then let the pipeline settle
  task wait_drained(int unsigned settle);
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pixel_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pixel_sb.pending() != 0) begin
      pixel_sb.flush_missing();
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // both origin registers on back-to-back edges, block idle
  task set_origins(logic [15:0] x, logic [15:0] y);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ORIGIN_X;
    cfg_wdata_i <= x;
    @(posedge clk_i);
    pixel_sb.set_origin(CFG_ORIGIN_X, x);
    cfg_index_i <= CFG_ORIGIN_Y;
    cfg_wdata_i <= y;
    @(posedge clk_i);
    pixel_sb.set_origin(CFG_ORIGIN_Y, y);
    cfg_we_i <= 1'b0;
    origin_settings++;
  endtask

  // bytes lean towards the extremes now and then
  function logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function logic [15:0] pick_origin();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function void push_le(logic [31:0] v, int unsigned n);
    for (int i = 0; i < n; i++) begin
      file_bytes.push_back(v[8*i +: 8]);
    end
  endfunction

  function void push_random(int unsigned n);
    repeat (n) file_bytes.push_back(rand_byte());
  endfunction

  // 34-byte header, then filler up to a modest data offset
  function void push_header(logic [7:0] s0, logic [7:0] s1, logic [31:0] offset,
                            logic [31:0] wf, logic [31:0] hf, logic [15:0] bpp,
                            logic [31:0] comp);
    file_bytes.push_back(s0);
    file_bytes.push_back(s1);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le(offset, 4);
    push_le(32'd40, 4);
    push_le(wf, 4);
    push_le(hf, 4);
    push_le(32'd1, 2);
    push_le(32'(bpp), 2);
    push_le(comp, 4);
    if (offset > HEADER_LEN && offset < HEADER_LEN + 64) begin
      push_random(offset - HEADER_LEN);
    end
  endfunction

  // rows of b,g,r triples padded to four bytes
  function int unsigned image_bytes(int unsigned w, int unsigned h);
    return h * (3 * w + (w & 3));
  endfunction

  function void push_image(int unsigned w, int unsigned h, bit td, int unsigned gap,
                           int unsigned pix_limit, int unsigned tail);
    int unsigned n;
    n = image_bytes(w, h);
    if (n > pix_limit) begin
      n = pix_limit;
    end
    push_header(SIG_B, SIG_M, HEADER_LEN + gap, 32'(w),
                td ? 32'd0 - 32'(h) : 32'(h), BPP_24, 32'd0);
    push_random(n);
    push_random(tail);
  endfunction

  initial begin
    int unsigned file_idx, kind, w, h, full, rand_start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_origins(16'h0000, 16'h0000);

    // stray bytes before any start flag are dropped
    send_byte(SIG_B, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    // single pixels carrying the colour extremes, bottom-up then top-down
    push_image(1, 1, 1'b0, 0, 0, 0);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    send_file();
    push_image(1, 1, 1'b1, 0, 0, 0);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    send_file();

    // padding lengths of two, three and zero bytes, a gap before the pixels and junk after the image
    push_image(2, 2, 1'b1, 6, NO_LIMIT, 3);
    send_file();
    push_image(3, 2, 1'b0, 0, NO_LIMIT, 0);
    send_file();
    push_image(4, 1, 1'b0, 1, NO_LIMIT, 0);
    send_file();

    // rejected headers: signature, bits per pixel, compression, short offset
    push_header(8'h62, SIG_M, 34, 2, 2, BPP_24, 0);
    push_random(image_bytes(2, 2));
    send_file();
    push_header(SIG_B, 8'h6D, 34, 2, 2, BPP_24, 0);
    push_random(image_bytes(2, 2));
    send_file();
    push_header(SIG_B, SIG_M, 34, 2, 1, 16'd32, 0);
    push_random(image_bytes(2, 1));
    send_file();
    push_header(SIG_B, SIG_M, 34, 2, 1, BPP_24, 32'd1);
    push_random(image_bytes(2, 1));
    send_file();
    push_header(SIG_B, SIG_M, 34, 2, 1, BPP_24, 32'h0100_0000);
    push_random(image_bytes(2, 1));
    send_file();
    push_header(SIG_B, SIG_M, 33, 2, 1, BPP_24, 0);
    push_random(image_bytes(2, 1));
    send_file();
    // pixel data far beyond the end of the file
    push_header(SIG_B, SIG_M, 32'h8000_0000, 2, 1, BPP_24, 0);
    push_random(12);
    send_file();

    // long stretch with no idling on either side
    steady_flow = 1'b1;

    // side limits: one past the limit is rejected, the limit itself is cut short
    push_header(SIG_B, SIG_M, 34, 32'(MAX_SIDE + 1), 1, BPP_24, 0);
    push_random(12);
    send_file();
    push_image(MAX_SIDE, 1, 1'b0, 0, 30, 0);
    send_file();
    push_header(SIG_B, SIG_M, 34, 2, 32'(MAX_SIDE + 1), BPP_24, 0);
    push_random(12);
    send_file();
    push_image(2, MAX_SIDE, 1'b1, 0, 48, 0);
    send_file();
    push_header(SIG_B, SIG_M, 34, 2, 32'd0 - 32'(MAX_SIDE + 1), BPP_24, 0);
    push_random(12);
    send_file();
    push_header(SIG_B, SIG_M, 34, 2, 32'h8000_0000, BPP_24, 0);
    push_random(12);
    send_file();

    // empty images: negative width, zero width, zero height
    push_header(SIG_B, SIG_M, 34, 32'd0 - 32'd3, 2, BPP_24, 0);
    push_random(24);
    send_file();
    push_header(SIG_B, SIG_M, 34, 0, 2, BPP_24, 0);
    push_random(12);
    send_file();
    push_header(SIG_B, SIG_M, 34, 2, 0, BPP_24, 0);
    push_random(12);
    send_file();

    steady_flow = 1'b0;

    // restart in the middle of the pixel data
    push_image(3, 3, 1'b0, 0, 10, 0);
    send_file();

    // coordinate wrap at both origin extremes
    wait_drained(SETTLE_CYCLES);
    set_origins(16'h7FFF, 16'h8000);
    push_image(3, 3, 1'b0, 0, NO_LIMIT, 0);
    send_file();
    push_image(5, 2, 1'b1, 0, NO_LIMIT, 0);
    send_file();
    wait_drained(SETTLE_CYCLES);
    set_origins(16'h8000, 16'h7FFF);
    push_image(2, 3, 1'b0, 0, NO_LIMIT, 0);
    send_file();
    push_image(3, 2, 1'b1, 0, NO_LIMIT, 0);
    send_file();

    // random files: mostly well formed, some huge sides, corrupt headers and noise
    file_idx   = 0;
    rand_start = file_bytes_sent;
    while (file_bytes_sent - rand_start < RANDOM_BYTES) begin
      if (file_idx % 12 == 0) begin
        wait_drained(SETTLE_CYCLES);
        set_origins(pick_origin(), pick_origin());
      end
      kind = $urandom_range(99);
      if (kind < 62) begin
        w    = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(7, 1);
        h    = $urandom_range(5, 1);
        full = image_bytes(w, h);
        push_image(w, h, $urandom_range(1), ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0,
                   ($urandom_range(9) == 0) ? $urandom_range(full) : NO_LIMIT,
                   ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0);
        send_file();
      end else if (kind < 70) begin
        if ($urandom_range(1)) begin
          push_image(MAX_SIDE, $urandom_range(3, 1), $urandom_range(1), 0,
                     $urandom_range(240), 0);
        end else begin
          push_image($urandom_range(3, 1), MAX_SIDE, $urandom_range(1), 0,
                     $urandom_range(240), 0);
        end
        send_file();
      end else if (kind < 88) begin
        // one header byte replaced: may reject, reshape or relocate the image
        push_image($urandom_range(6, 1), $urandom_range(4, 1), $urandom_range(1),
                   $urandom_range(2), NO_LIMIT, 0);
        file_bytes[$urandom_range(HEADER_LEN - 1)] = rand_byte();
        send_file();
      end else begin
        // loose bytes, some flagged as a new start
        repeat ($urandom_range(30, 4)) send_byte(rand_byte(), $urandom_range(7) == 0);
      end
      file_idx++;
    end
    steady_flow = 1'b0;

    wait_drained(20);
    $display("covered %0d files (%0d bytes) under %0d origin settings, %0d pixels checked",
             files_sent, file_bytes_sent, origin_settings, pixel_sb.pixels_checked);
    if (pixel_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", pixel_sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
